// ===== design/rbfe_pkg.sv =====
// Shared types, constants and frame-building function for the RC5 biphase encoder.
// No dependencies; imported by every module of the block.
package rbfe_pkg;

    // Frame layout
    localparam int CONTROL_BITS = 7;
    localparam int COMMAND_BITS = 6;
    localparam int FULL_BITS    = 13;
    localparam int STD_BITS     = CONTROL_BITS + COMMAND_BITS;
    localparam int FRAME_MAX    = (STD_BITS > FULL_BITS) ? STD_BITS : FULL_BITS;

    // Half-bit stream: lead pulse plus two halves per frame bit
    localparam int HALVES_W    = 1 + 2 * FRAME_MAX;
    localparam int HALVES_STD  = 1 + 2 * STD_BITS;
    localparam int HALVES_FULL = 1 + 2 * FULL_BITS;
    localparam int CNT_W       = $clog2(HALVES_W + 1);

    // Field widths
    localparam int HBT_W   = 12;
    localparam int CW_W    = 7;
    localparam int KEY_W   = 13;
    localparam int DUR_W   = 13;
    localparam int FTIME_W = 17;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_CONTROL_WORD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_WORD     = 2'd2;

    // Reset values
    localparam logic [HBT_W-1:0] HBT_RESET = 12'd889;

    typedef logic [FRAME_MAX-1:0] t_bits;
    typedef logic [HALVES_W-1:0]  t_halves;
    typedef logic [CNT_W-1:0]     t_count;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic final_word;
    } t_dp_status;

    // Frame bits, MSB first and left aligned; toggle applied to the second bit
    function automatic t_bits frame_bits(
        input logic             use_cw,
        input logic [CW_W-1:0]  cw,
        input logic [KEY_W-1:0] key,
        input logic             parity
    );
        t_bits res;
        logic  b;
        int    idx;
        res = '0;
        for (int i = 0; i < FRAME_MAX; i++) begin
            b = 1'b0;
            if (use_cw) begin
                if (i < CONTROL_BITS) begin
                    idx = CONTROL_BITS - 1 - i;
                    if (idx < CW_W) begin
                        b = cw[idx];
                    end
                end else if (i < STD_BITS) begin
                    idx = COMMAND_BITS - 1 - (i - CONTROL_BITS);
                    if (idx < KEY_W) begin
                        b = key[idx];
                    end
                end
            end else begin
                if (i < FULL_BITS) begin
                    idx = FULL_BITS - 1 - i;
                    if (idx < KEY_W) begin
                        b = key[idx];
                    end
                end
            end
            if (i == 1) begin
                b = b ^ parity;
            end
            res[FRAME_MAX-1-i] = b;
        end
        return res;
    endfunction

    // Biphase expansion: lead pulse, then 0 -> pulse,space and 1 -> space,pulse
    function automatic t_halves expand_halves(input t_bits bits);
        t_halves res;
        res = '0;
        res[HALVES_W-1] = 1'b1;
        for (int i = 0; i < FRAME_MAX; i++) begin
            res[HALVES_W-2-2*i] = ~bits[FRAME_MAX-1-i];
            res[HALVES_W-3-2*i] = bits[FRAME_MAX-1-i];
        end
        return res;
    endfunction

endpackage

// ===== design/rbfe_ctrl.sv =====
// Controller FSM for the RC5 biphase encoder: accepts frames and paces emission.
// Depends on rbfe_pkg.
module rbfe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rbfe_pkg::t_dp_status i_status,
    output rbfe_pkg::t_dp_cmd    o_cmd
);
    import rbfe_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.out_free && i_status.final_word) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_RUN: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== design/rbfe_datapath.sv =====
// Datapath of the RC5 biphase encoder: config registers, toggle parity,
// half-bit shift register, run merging, frame time sum and output register.
// Depends on rbfe_pkg.
module rbfe_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [rbfe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    // input word
    input  logic [rbfe_pkg::KEY_W-1:0]         i_key_code,
    input  logic                               i_end_of_press,
    // control
    input  rbfe_pkg::t_dp_cmd                  i_cmd,
    output rbfe_pkg::t_dp_status               o_status,
    // output word
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_level,
    output logic [rbfe_pkg::DUR_W-1:0]         o_duration,
    output logic                               o_last,
    output logic [rbfe_pkg::FTIME_W-1:0]       o_frame_time
);
    import rbfe_pkg::*;

    logic [HBT_W-1:0]   r_half_bit_time;
    logic               r_use_cw;
    logic [CW_W-1:0]    r_control_word;
    logic               r_parity;

    t_halves            r_halves;
    t_count             r_left;
    logic [FTIME_W-1:0] r_total;

    logic               r_out_valid;
    logic               r_level;
    logic [DUR_W-1:0]   r_duration;
    logic               r_last;
    logic [FTIME_W-1:0] r_frame_time;

    logic               lvl;
    logic               pair;
    logic [DUR_W-1:0]   dur;
    t_count             left_next;
    logic [FTIME_W-1:0] sum;
    logic               is_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit_time <= HBT_RESET;
            r_use_cw        <= 1'b1;
            r_control_word  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_BIT_TIME:    r_half_bit_time <= i_cfg_data[HBT_W-1:0];
                CFG_USE_CONTROL_WORD: r_use_cw        <= i_cfg_data[0];
                CFG_CONTROL_WORD:     r_control_word  <= i_cfg_data[CW_W-1:0];
                default: ;
            endcase
        end
    end

    // Toggle parity flips on each accepted end-of-press frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_cmd.load && i_end_of_press) begin
            r_parity <= ~r_parity;
        end
    end

    // Current run: one or two equal halves at the head of the stream
    always_comb begin
        lvl       = r_halves[HALVES_W-1];
        pair      = (r_left > t_count'(1)) && (r_halves[HALVES_W-2] == lvl);
        dur       = pair ? {r_half_bit_time, 1'b0} : {1'b0, r_half_bit_time};
        left_next = pair ? (r_left - t_count'(2)) : (r_left - t_count'(1));
        is_last   = (left_next == '0);
        sum       = r_total + FTIME_W'(dur);
    end

    // Half-bit stream, remaining count and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.load) begin
            r_left <= r_use_cw ? t_count'(HALVES_STD) : t_count'(HALVES_FULL);
        end else if (i_cmd.emit) begin
            r_left <= left_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_halves <= expand_halves(frame_bits(r_use_cw, r_control_word,
                                                 i_key_code, r_parity));
            r_total  <= '0;
        end else if (i_cmd.emit) begin
            r_halves <= pair ? {r_halves[HALVES_W-3:0], 2'b00}
                             : {r_halves[HALVES_W-2:0], 1'b0};
            r_total  <= sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_level      <= lvl;
            r_duration   <= dur;
            r_last       <= is_last;
            r_frame_time <= is_last ? sum : '0;
        end
    end

    // Status to controller
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.final_word = is_last;

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_level;
    assign o_duration   = r_duration;
    assign o_last       = r_last;
    assign o_frame_time = r_frame_time;

endmodule

// ===== design/rc5_biphase_frame_encoder.sv =====
// Top level of the RC5 biphase frame encoder.
// Depends on rbfe_pkg, rbfe_ctrl and rbfe_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one frame request word:
//   i_key_code and i_end_of_press. Output channel (o_out_valid /
//   i_out_stall) delivers the frame as alternating pulse and space words:
//   o_level, o_duration, with o_last and o_frame_time on the final word.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set
//   half-bit time, frame mode and control word; write them while idle.
//   A frame's first word is registered after the shift register is loaded.
//   Throughput: one word per cycle, 14 to 27 words per frame (runs of two
//   equal halves merge), set by the half-bit shift register advancing one
//   run per cycle. The next frame is accepted in the cycle after the last
//   word is loaded into the output register, even while that word waits.
//   Receiver stall holds the output register and pauses the shifting.
//   Reset: half-bit time 889, standard mode, control word 0, toggle parity
//   0, no word pending.
module rc5_biphase_frame_encoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rbfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rbfe_pkg::KEY_W-1:0]          i_key_code,
    input  logic                                i_end_of_press,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_level,
    output logic [rbfe_pkg::DUR_W-1:0]          o_duration,
    output logic                                o_last,
    output logic [rbfe_pkg::FTIME_W-1:0]        o_frame_time
);
    import rbfe_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // Controller
    rbfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath
    rbfe_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_key_code     (i_key_code),
        .i_end_of_press (i_end_of_press),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_level        (o_level),
        .o_duration     (o_duration),
        .o_last         (o_last),
        .o_frame_time   (o_frame_time)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for rc5_biphase_frame_encoder: directed frame table, then random phases.
// Depends on rbfe_pkg and the encoder RTL; predicts every pulse/space word on its own.
`timescale 1ns / 100ps

module tb;
    import rbfe_pkg::*;

    // Index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int PHASES       = 6;
    localparam int PHASE_FRAMES = 80;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 1500;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int PLAN_ROWS    = 28;

    // One pulse or space word of a frame
    typedef struct packed {
        logic               level;
        logic [DUR_W-1:0]   duration;
        logic               last;
        logic [FTIME_W-1:0] frame_time;
    } mark_t;

    typedef enum logic {
        ROW_FRAME,
        ROW_REG
    } row_kind_t;

    // words / ftime of -1: not typed in, left to the predictor
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        logic [KEY_W-1:0]     key;
        logic                 eop;
        int                   words;
        int                   ftime;
    } plan_row_t;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [31:0]          i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic [KEY_W-1:0]     i_key_code     = '0;
    logic                 i_end_of_press = 1'b0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_level;
    logic [DUR_W-1:0]     o_duration;
    logic                 o_last;
    logic [FTIME_W-1:0]   o_frame_time;

    // Shadow copy of the block's registers and press parity
    logic [HBT_W-1:0] half_bit = HBT_RESET;
    logic             std_mode = 1'b1;
    logic [CW_W-1:0]  ctrl_word = '0;
    logic             press_parity = 1'b0;

    mark_t pending_marks[$];
    int    errors = 0;
    int    marks_seen = 0;
    bit    calm = 1'b0;

    // Directed frames; idx/data only matter on register rows
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_FRAME, '0, '0, 13'h0000, 1'b0, 26, 24003},   // all zero after reset
        '{ROW_FRAME, '0, '0, 13'h1FFF, 1'b0, 25, 24003},   // max key, low six bits used
        '{ROW_FRAME, '0, '0, 13'h002A, 1'b1, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h0015, 1'b0, -1, -1},      // toggle bit inverted
        '{ROW_FRAME, '0, '0, 13'h0000, 1'b1, -1, -1},
        '{ROW_REG, CFG_CONTROL_WORD, 32'd127, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h0000, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h003F, 1'b0, 27, 24003},   // all ones, no merging
        '{ROW_REG, CFG_USE_CONTROL_WORD, 32'd0, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h1FFF, 1'b0, 27, 24003},
        '{ROW_FRAME, '0, '0, 13'h0000, 1'b1, 26, 24003},
        '{ROW_FRAME, '0, '0, 13'h1555, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h0AAA, 1'b1, -1, -1},
        '{ROW_REG, CFG_HALF_BIT_TIME, 32'd4095, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h1FFF, 1'b0, 27, 110565},  // longest frame time
        '{ROW_REG, CFG_HALF_BIT_TIME, 32'd0, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h1234, 1'b1, -1, 0},       // zero half-bit time
        '{ROW_REG, CFG_HALF_BIT_TIME, 32'd1, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h0000, 1'b1, -1, 27},
        '{ROW_REG, CFG_SPARE, 32'hFFFF_FFFF, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h1FFF, 1'b0, 27, 27},      // spare write had no effect
        '{ROW_REG, CFG_USE_CONTROL_WORD, 32'hFFFF_FFFE, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h0001, 1'b0, -1, -1},
        '{ROW_REG, CFG_USE_CONTROL_WORD, 32'd1, '0, 1'b0, -1, -1},
        '{ROW_REG, CFG_CONTROL_WORD, 32'hFFFF_FF55, '0, 1'b0, -1, -1},
        '{ROW_REG, CFG_HALF_BIT_TIME, 32'hFFFF_F889, '0, 1'b0, -1, -1},
        '{ROW_FRAME, '0, '0, 13'h000F, 1'b1, -1, 58995},
        '{ROW_FRAME, '0, '0, 13'h0030, 1'b0, -1, 58995}
    };

    rc5_biphase_frame_encoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_key_code     (i_key_code),
        .i_end_of_press (i_end_of_press),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_level        (o_level),
        .o_duration     (o_duration),
        .o_last         (o_last),
        .o_frame_time   (o_frame_time)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Expand one request into merged pulse/space words and queue them
    task automatic build_frame_marks(input logic [KEY_W-1:0] key, input logic eop,
                                     output int n_words, output logic [FTIME_W-1:0] total);
        logic             halves[$];
        logic             b;
        logic             lvl;
        logic [DUR_W-1:0] dur;
        mark_t            m;
        int               pos;
        halves = {1'b1};  // lead pulse
        if (std_mode) begin
            for (int i = 0; i < CONTROL_BITS; i++) begin
                b = ctrl_word[CONTROL_BITS-1-i] ^ ((i == 1) ? press_parity : 1'b0);
                halves.push_back(~b);
                halves.push_back(b);
            end
            for (int i = 0; i < COMMAND_BITS; i++) begin
                b = key[COMMAND_BITS-1-i];
                halves.push_back(~b);
                halves.push_back(b);
            end
        end else begin
            for (int i = 0; i < FULL_BITS; i++) begin
                b = key[FULL_BITS-1-i] ^ ((i == 1) ? press_parity : 1'b0);
                halves.push_back(~b);
                halves.push_back(b);
            end
        end
        pos = 0;
        n_words = 0;
        total = '0;
        while (pos < halves.size()) begin
            lvl = halves[pos];
            dur = '0;
            while (pos < halves.size() && halves[pos] == lvl) begin
                dur = dur + DUR_W'(half_bit);
                pos++;
            end
            total = total + FTIME_W'(dur);
            m.level = lvl;
            m.duration = dur;
            m.last = (pos >= halves.size());
            m.frame_time = m.last ? total : '0;
            pending_marks.push_back(m);
            n_words++;
        end
        if (eop) begin
            press_parity = ~press_parity;
        end
    endtask

    // Register write, only once every queued word has come out
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_in_valid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_HALF_BIT_TIME:    half_bit = data[HBT_W-1:0];
            CFG_USE_CONTROL_WORD: std_mode = data[0];
            CFG_CONTROL_WORD:     ctrl_word = data[CW_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one request, wait for acceptance, maybe idle afterwards
    task automatic send_frame(input logic [KEY_W-1:0] key, input logic eop,
                              output int n_words, output logic [FTIME_W-1:0] total);
        i_cfg_valid <= 1'b0;
        i_in_valid <= 1'b1;
        i_key_code <= key;
        i_end_of_press <= eop;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        build_frame_marks(key, eop, n_words, total);
        if (!calm && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Random register writes between phases, extremes weighted in
    task automatic pick_settings();
        int                   n;
        int                   pick;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          noise;
        logic [HBT_W-1:0]     h;
        n = $urandom_range(1, 4);
        repeat (n) begin
            idx = CFG_IDX_W'($urandom_range(0, 3));
            noise = $urandom;
            case (idx)
                CFG_HALF_BIT_TIME: begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0) h = '0;
                    else if (pick < 3) h = 12'd1;
                    else if (pick < 5) h = 12'd4095;
                    else h = HBT_W'($urandom_range(1, 4095));
                    set_reg(idx, {noise[31:HBT_W], h});
                end
                CFG_USE_CONTROL_WORD: set_reg(idx, {noise[31:1], 1'($urandom_range(0, 1))});
                CFG_CONTROL_WORD:     set_reg(idx, {noise[31:CW_W], CW_W'($urandom_range(0, 127))});
                default:              set_reg(idx, noise);
            endcase
        end
    endtask

    // Request side: reset, directed table, random phases, drain
    initial begin : frame_source
        int                 n_words;
        int                 cycles;
        logic [FTIME_W-1:0] total;
        logic [KEY_W-1:0]   key;
        logic               eop;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].kind == ROW_REG) begin
                set_reg(plan[r].idx, plan[r].data);
            end else begin
                send_frame(plan[r].key, plan[r].eop, n_words, total);
                if ((plan[r].words >= 0 && n_words != plan[r].words) ||
                    (plan[r].ftime >= 0 && int'(total) != plan[r].ftime)) begin
                    $display("%0t: row %0d words exp %0d act %0d, frame time exp %0d act %0d",
                             $time, r, plan[r].words, n_words, plan[r].ftime, total);
                    errors++;
                end
            end
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            pick_settings();
            if (ph == PHASES - 1) calm = 1'b1;
            repeat (PHASE_FRAMES) begin
                key = KEY_W'($urandom_range(0, 8191));
                eop = ($urandom_range(0, 3) == 0);
                send_frame(key, eop, n_words, total);
            end
        end
        i_in_valid <= 1'b0;
        cycles = 0;
        while (pending_marks.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_marks.size() != 0) begin
            $display("%0t: %0d words never arrived", $time, pending_marks.size());
            errors++;
        end
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // Output stall: random bursts, one long hold-off, none at the end
    initial begin : stall_source
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!hold_done && marks_seen >= HOLD_AFTER) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 4) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin : word_check
        mark_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            marks_seen++;
            if (pending_marks.size() == 0) begin
                $display("%0t: unexpected word level %0d duration %0d last %0d frame time %0d",
                         $time, o_level, o_duration, o_last, o_frame_time);
                errors++;
            end else begin
                want = pending_marks.pop_front();
                if (o_level !== want.level) begin
                    $display("%0t: level exp %0d act %0d", $time, want.level, o_level);
                    errors++;
                end
                if (o_duration !== want.duration) begin
                    $display("%0t: duration exp %0d act %0d", $time, want.duration, o_duration);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last exp %0d act %0d", $time, want.last, o_last);
                    errors++;
                end
                if (o_frame_time !== want.frame_time) begin
                    $display("%0t: frame time exp %0d act %0d",
                             $time, want.frame_time, o_frame_time);
                    errors++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
